>>> hw/rtl/ghc_pkg.sv
// greenhouse hysteresis controller package: field widths, limits, register indexes,
// and the shared structs for config, sample, state and result
// no dependencies
`default_nettype none

package ghc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_ON   = 3'd0,
        REG_TEMP_OFF  = 3'd1,
        REG_HUMID_ON  = 3'd2,
        REG_HUMID_OFF = 3'd3,
        REG_SOIL_DRY  = 3'd4,
        REG_SOIL_WET  = 3'd5,
        REG_LIGHT_LOW = 3'd6,
        REG_LIGHT_HI  = 3'd7
    } ghc_reg_idx_t;

    localparam logic signed [11:0] CLIMATE_TEMP_MIN  = -12'sd400;
    localparam logic signed [11:0] CLIMATE_TEMP_MAX  = 12'sd800;
    localparam logic [9:0]         CLIMATE_HUMID_MAX = 10'd1000;
    localparam logic [15:0]        LIGHT_ERROR_CODE  = 16'hFFFF;
    localparam logic [31:0]        PUMP_RUN_LIMIT_MS = 32'd60000;

    localparam logic signed [10:0] TEMP_ON_RST   = 11'sd300;
    localparam logic signed [10:0] TEMP_OFF_RST  = 11'sd280;
    localparam logic [9:0]         HUMID_ON_RST  = 10'd850;
    localparam logic [9:0]         HUMID_OFF_RST = 10'd750;
    localparam logic [9:0]         SOIL_DRY_RST  = 10'd400;
    localparam logic [9:0]         SOIL_WET_RST  = 10'd600;
    localparam logic [15:0]        LIGHT_LOW_RST = 16'd200;
    localparam logic [15:0]        LIGHT_HI_RST  = 16'd500;

    typedef struct packed {
        logic signed [10:0] temp_on_level;
        logic signed [10:0] temp_off_level;
        logic [9:0]         humid_on_level;
        logic [9:0]         humid_off_level;
        logic [9:0]         soil_dry_level;
        logic [9:0]         soil_wet_level;
        logic [15:0]        light_low_level;
        logic [15:0]        light_high_level;
    } ghc_cfg_t;

    typedef struct packed {
        logic signed [11:0] air_temp;
        logic [9:0]         air_humidity;
        logic               climate_read_failed;
        logic [9:0]         soil_level;
        logic [15:0]        light_level;
        logic [31:0]        now_ms;
    } ghc_sample_t;

    typedef struct packed {
        logic        fan;
        logic        pump;
        logic        grow;
        logic [31:0] pump_started_at;
    } ghc_state_t;

    typedef struct packed {
        logic fan_drive;
        logic pump_drive;
        logic grow_drive;
        logic climate_fault;
        logic light_fault;
    } ghc_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/ghc_cfg_regs.sv
// threshold register file for the greenhouse controller, written through a plain write port
// depends on ghc_pkg
`default_nettype none

module ghc_cfg_regs
    import ghc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output ghc_cfg_t                   cfg
);

    ghc_cfg_t cfg_reg;
    ghc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (ghc_reg_idx_t'(cfg_index))
                REG_TEMP_ON:   cfg_next.temp_on_level    = cfg_data[10:0];
                REG_TEMP_OFF:  cfg_next.temp_off_level   = cfg_data[10:0];
                REG_HUMID_ON:  cfg_next.humid_on_level   = cfg_data[9:0];
                REG_HUMID_OFF: cfg_next.humid_off_level  = cfg_data[9:0];
                REG_SOIL_DRY:  cfg_next.soil_dry_level   = cfg_data[9:0];
                REG_SOIL_WET:  cfg_next.soil_wet_level   = cfg_data[9:0];
                REG_LIGHT_LOW: cfg_next.light_low_level  = cfg_data;
                REG_LIGHT_HI:  cfg_next.light_high_level = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.temp_on_level    <= TEMP_ON_RST;
            cfg_reg.temp_off_level   <= TEMP_OFF_RST;
            cfg_reg.humid_on_level   <= HUMID_ON_RST;
            cfg_reg.humid_off_level  <= HUMID_OFF_RST;
            cfg_reg.soil_dry_level   <= SOIL_DRY_RST;
            cfg_reg.soil_wet_level   <= SOIL_WET_RST;
            cfg_reg.light_low_level  <= LIGHT_LOW_RST;
            cfg_reg.light_high_level <= LIGHT_HI_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> hw/rtl/ghc_update.sv
// next-state logic for fan, pump and grow light with hysteresis, plus fault flags
// purely combinational; depends on ghc_pkg
`default_nettype none

module ghc_update
    import ghc_pkg::*;
(
    input  wire ghc_cfg_t    cfg,
    input  wire ghc_sample_t sample,
    input  wire ghc_state_t  state,
    output ghc_state_t       state_next,
    output ghc_result_t      result
);

    logic              climate_ok;
    logic              light_bad;
    logic signed [11:0] temp_on_ext;
    logic signed [11:0] temp_off_ext;
    logic [31:0]       elapsed;
    logic              soil_dry;
    logic              pump_overrun;

    assign temp_on_ext  = {cfg.temp_on_level[10], cfg.temp_on_level};
    assign temp_off_ext = {cfg.temp_off_level[10], cfg.temp_off_level};

    assign climate_ok = !sample.climate_read_failed
                        && (sample.air_temp >= CLIMATE_TEMP_MIN)
                        && (sample.air_temp <= CLIMATE_TEMP_MAX)
                        && (sample.air_humidity <= CLIMATE_HUMID_MAX);

    // wrap-around runtime since pump start
    assign elapsed      = sample.now_ms - state.pump_started_at;
    assign pump_overrun = state.pump && (elapsed > PUMP_RUN_LIMIT_MS);
    assign soil_dry     = (sample.soil_level != '0)
                          && (sample.soil_level <= cfg.soil_dry_level);

    assign light_bad = (sample.light_level == LIGHT_ERROR_CODE);

    always_comb
    begin
        state_next = state;

        if (climate_ok)
        begin
            priority if ((sample.air_temp >= temp_on_ext)
                         || (sample.air_humidity >= cfg.humid_on_level))
                state_next.fan = 1'b1;
            else if ((sample.air_temp <= temp_off_ext)
                     && (sample.air_humidity <= cfg.humid_off_level))
                state_next.fan = 1'b0;
            else
                state_next.fan = state.fan;
        end

        priority if (soil_dry && !state.pump)
        begin
            state_next.pump            = 1'b1;
            state_next.pump_started_at = sample.now_ms;
        end
        else if ((sample.soil_level >= cfg.soil_wet_level) || pump_overrun)
        begin
            state_next.pump = 1'b0;
        end
        else
        begin
            state_next.pump = state.pump;
        end

        if (!light_bad)
        begin
            priority if ((sample.light_level != '0)
                         && (sample.light_level <= cfg.light_low_level) && !state.grow)
                state_next.grow = 1'b1;
            else if ((sample.light_level >= cfg.light_high_level) && state.grow)
                state_next.grow = 1'b0;
            else
                state_next.grow = state.grow;
        end
    end

    assign result.fan_drive     = state_next.fan;
    assign result.pump_drive    = state_next.pump;
    assign result.grow_drive    = state_next.grow;
    assign result.climate_fault = !climate_ok;
    assign result.light_fault   = light_bad;

endmodule

`default_nettype wire

>>> hw/rtl/greenhouse_hysteresis_controller.sv
// Greenhouse hysteresis controller: one sample in, one fan/pump/grow-light result out. A sample
// is taken every cycle while out_ready stays high; the result is held in the result register
// behind the input register, with the combinational state update in between. Thresholds are
// written through cfg_wr_en/cfg_index/cfg_data while no transaction is in flight; the user must
// keep to this, as the block itself does not enforce it.
// depends on ghc_pkg, ghc_cfg_regs, ghc_update
`default_nettype none

module greenhouse_hysteresis_controller
    import ghc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic signed [11:0]    air_temp,
    input  wire logic [9:0]            air_humidity,
    input  wire logic                  climate_read_failed,
    input  wire logic [9:0]            soil_level,
    input  wire logic [15:0]           light_level,
    input  wire logic [31:0]           now_ms,

    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       fan_drive,
    output logic                       pump_drive,
    output logic                       grow_drive,
    output logic                       climate_fault,
    output logic                       light_fault
);

    ghc_cfg_t    cfg;
    ghc_sample_t sample_reg;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    ghc_state_t  state_reg;
    ghc_state_t  state_next;
    ghc_result_t res_reg;
    ghc_result_t res_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        in_take;
    logic        advance;

    ghc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ghc_update u_update (
        .cfg        (cfg),
        .sample     (sample_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (res_next)
    );

    // sample moves on when the result register is free or being drained
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    assign s1_valid_next  = in_take || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sample_reg.air_temp            <= air_temp;
            sample_reg.air_humidity        <= air_humidity;
            sample_reg.climate_read_failed <= climate_read_failed;
            sample_reg.soil_level          <= soil_level;
            sample_reg.light_level         <= light_level;
            sample_reg.now_ms              <= now_ms;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign fan_drive     = res_reg.fan_drive;
    assign pump_drive    = res_reg.pump_drive;
    assign grow_drive    = res_reg.grow_drive;
    assign climate_fault = res_reg.climate_fault;
    assign light_fault   = res_reg.light_fault;

    // an empty result register never blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("in_ready low while result register empty");

    // the held result always mirrors the stored drive states
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (fan_drive == state_reg.fan) && (pump_drive == state_reg.pump)
                          && (grow_drive == state_reg.grow))
        else $error("result drives disagree with stored state");

    // a pump start records the sample timestamp
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !state_reg.pump && state_next.pump)
            |=> (state_reg.pump_started_at == $past(sample_reg.now_ms)))
        else $error("pump start time not captured");

    // a light error leaves the grow light untouched
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (sample_reg.light_level == LIGHT_ERROR_CODE))
            |=> (state_reg.grow == $past(state_reg.grow)))
        else $error("grow light changed on light error");

endmodule

`default_nettype wire
